### rtl/sir_rk4_step_assert.svh
// Assertion macros shared by the SIR step RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef SIR_RK4_STEP_ASSERT_SVH
`define SIR_RK4_STEP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in same cycle");

// Antecedent implies consequent in the next cycle.
`define SIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in next cycle");

`endif

### rtl/sir_pkg.sv
// Shared types, constants and saturating helpers for the SIR Runge-Kutta step.
// Used by sir_mul, sir_slope and sir_rk4_step; depends on nothing.
package sir_pkg;

	// Fraction format and configuration widths.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = DATA_WIDTH - 2;
	localparam int OW         = DATA_WIDTH - 1;
	localparam int CFG_WIDTH  = 32;
	localparam int IDX_WIDTH  = 2;

	// Intermediate values are signed and saturate at +-(2^(DATA_WIDTH+13)-1).
	localparam int IW = DATA_WIDTH + 14;

	// Multiplier operand magnitude width, halves and full product width.
	localparam int AW  = (DATA_WIDTH + 13 > CFG_WIDTH) ? DATA_WIDTH + 13 : CFG_WIDTH;
	localparam int XW  = AW + 1;
	localparam int HW  = (AW + 1) / 2;
	localparam int PW  = 4 * HW;
	localparam int SHW = 6;

	// Fraction bits of the coefficients.
	localparam int RATE_FRAC  = 24;
	localparam int STEP_FRAC  = 28;
	localparam int RECIP_FRAC = 32;
	localparam logic [CFG_WIDTH-1:0] RECIP_SIX = 32'd715827883;

	// Register reset values.
	localparam logic [CFG_WIDTH-1:0] BETA_RST  = 32'd5033165;
	localparam logic [CFG_WIDTH-1:0] GAMMA_RST = 32'd1677722;
	localparam logic [CFG_WIDTH-1:0] DT_RST    = 32'd26843546;

	// Stream widths, whole bytes.
	localparam int IN_TDW  = ((3 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDW = ((3 * OW + 7) / 8) * 8;

	// Pipeline latencies.
	localparam int MUL_LAT   = 3;
	localparam int SLOPE_LAT = 3 * MUL_LAT + 1;

	typedef logic signed [IW-1:0] ival_t;

	// Largest magnitude of an intermediate value.
	localparam ival_t LIM = {1'b0, {(IW-1){1'b1}}};

	// Configuration register indexes.
	typedef enum logic [IDX_WIDTH-1:0] {
		REG_INFECTION = 2'd0,
		REG_RECOVERY  = 2'd1,
		REG_STEP      = 2'd2
	} reg_idx_t;

	// One set of slopes (already scaled by dt).
	typedef struct packed {
		ival_t ks;
		ival_t ki;
		ival_t kr;
	} kv_t;

	// Clamped input fractions.
	typedef struct packed {
		logic [OW-1:0] s;
		logic [OW-1:0] i;
		logic [OW-1:0] r;
	} xv_t;

	// Saturating add within the intermediate range.
	function automatic ival_t sat_add(ival_t a, ival_t b);
		logic signed [IW:0] w;
		w = $signed({a[IW-1], a}) + $signed({b[IW-1], b});
		if (w > $signed({1'b0, LIM})) begin
			sat_add = LIM;
		end else if (w < -$signed({1'b0, LIM})) begin
			sat_add = -LIM;
		end else begin
			sat_add = w[IW-1:0];
		end
	endfunction

	// Halving that truncates toward zero.
	function automatic ival_t half(ival_t x);
		ival_t t;
		t = x + $signed({{(IW-1){1'b0}}, x[IW-1]});
		half = t >>> 1;
	endfunction

endpackage

### rtl/sir_rk4_step.sv
// Throughput one item per cycle while no result waits untaken at the output.
// The four slope evaluations each pass through three chained multiply units.
// A stalled result freezes the whole pipeline until it is taken; nothing is lost.
// Reset clears every valid bit and loads the rate and step registers with defaults.
// Configuration writes take effect on the next clock edge.
// Top level of the SIR fourth-order Runge-Kutta step; uses sir_pkg, sir_slope, sir_mul.
module sir_rk4_step (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [sir_pkg::IDX_WIDTH-1:0]     cfg_index,
	input  logic [sir_pkg::CFG_WIDTH-1:0]     cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sir_pkg::IN_TDW-1:0]        s_tdata,  // s_in, i_in, r_in
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sir_pkg::OUT_TDW-1:0]       m_tdata,  // s_out, i_out, r_out
	output logic [0:0]                        m_tuser   // saturated
);

	localparam int DW    = sir_pkg::DATA_WIDTH;
	localparam int OW    = sir_pkg::OW;
	localparam int IW    = sir_pkg::IW;
	localparam int XW    = sir_pkg::XW;
	localparam int L     = sir_pkg::SLOPE_LAT;
	localparam int T1    = 1 + L;
	localparam int T2    = T1 + 1 + L;
	localparam int T3    = T2 + 1 + L;
	localparam int T4    = T3 + 1 + L;
	localparam int XLEN  = T4 + sir_pkg::MUL_LAT + 1;
	localparam int DEPTH = T4 + sir_pkg::MUL_LAT + 3;

	logic [sir_pkg::CFG_WIDTH-1:0] beta_q, gam_q, dt_q;
	logic [DEPTH-1:0]              vld_q;
	logic                          en;

	sir_pkg::xv_t   xd_q [XLEN];
	sir_pkg::kv_t   k1l_q [T2-T1];
	sir_pkg::kv_t   a2_q [T3-T2];
	sir_pkg::kv_t   a3_q [T4-T3];
	sir_pkg::kv_t   k1, k2, k3, k4;
	sir_pkg::ival_t y1s_s12, y1i_s12, y2s_s23, y2i_s23, y3s_s34, y3i_s34;
	sir_pkg::kv_t   sum_s45;
	sir_pkg::ival_t scs, sci, scr;
	sir_pkg::kv_t   bs_s49;
	logic [OW-1:0]  so_s50, io_s50, ro_s50;
	logic           sat_s50;
	logic           fs, fi, fr;
	logic [OW-1:0]  es, ei, er;

	// Negative inputs load as zero.
	function automatic logic [OW-1:0] clamp_in(logic [DW-1:0] x);
		clamp_in = x[DW-1] ? '0 : x[OW-1:0];
	endfunction

	// Clamp a result to the output range; flag saturation.
	function automatic logic [OW:0] emit(sir_pkg::ival_t v);
		if (v[IW-1]) begin
			emit = '0;
		end else if (|v[IW-2:OW]) begin
			emit = {1'b1, {OW{1'b1}}};
		end else begin
			emit = {1'b0, v[OW-1:0]};
		end
	endfunction

	// Twice a value plus an accumulator, in the order the sums saturate.
	function automatic sir_pkg::kv_t acc2(sir_pkg::kv_t acc, sir_pkg::kv_t k);
		acc2.ks = sir_pkg::sat_add(acc.ks, sir_pkg::sat_add(k.ks, k.ks));
		acc2.ki = sir_pkg::sat_add(acc.ki, sir_pkg::sat_add(k.ki, k.ki));
		acc2.kr = sir_pkg::sat_add(acc.kr, sir_pkg::sat_add(k.kr, k.kr));
	endfunction

	// The whole pipeline moves unless a result waits untaken.
	assign en       = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= sir_pkg::BETA_RST;
			gam_q  <= sir_pkg::GAMMA_RST;
			dt_q   <= sir_pkg::DT_RST;
		end else if (cfg_we) begin
			case (sir_pkg::reg_idx_t'(cfg_index))
				sir_pkg::REG_INFECTION: beta_q <= cfg_data;
				sir_pkg::REG_RECOVERY:  gam_q  <= cfg_data;
				sir_pkg::REG_STEP:      dt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// Clamped inputs and their delay line.
	always_ff @(posedge clk) begin
		if (en) begin
			xd_q[0] <= '{s: clamp_in(s_tdata[DW-1:0]),
			             i: clamp_in(s_tdata[2*DW-1:DW]),
			             r: clamp_in(s_tdata[3*DW-1:2*DW])};
			for (int n = 1; n < XLEN; n++) begin
				xd_q[n] <= xd_q[n-1];
			end
		end
	end

	// First slope from the initial state.
	sir_slope u_k1 (
		.clk(clk), .en(en), .s(IW'(xd_q[0].s)), .i(IW'(xd_q[0].i)),
		.beta(beta_q), .gam(gam_q), .dt(dt_q), .k(k1)
	);

	// Midpoint state for the second slope.
	always_ff @(posedge clk) begin
		if (en) begin
			y1s_s12 <= sir_pkg::sat_add(IW'(xd_q[T1-1].s), sir_pkg::half(k1.ks));
			y1i_s12 <= sir_pkg::sat_add(IW'(xd_q[T1-1].i), sir_pkg::half(k1.ki));
		end
	end

	sir_slope u_k2 (
		.clk(clk), .en(en), .s(y1s_s12), .i(y1i_s12),
		.beta(beta_q), .gam(gam_q), .dt(dt_q), .k(k2)
	);

	// Second midpoint; start the weighted sum with k1 + 2*k2.
	always_ff @(posedge clk) begin
		if (en) begin
			k1l_q[0] <= k1;
			for (int n = 1; n < T2-T1; n++) begin
				k1l_q[n] <= k1l_q[n-1];
			end
			y2s_s23 <= sir_pkg::sat_add(IW'(xd_q[T2-1].s), sir_pkg::half(k2.ks));
			y2i_s23 <= sir_pkg::sat_add(IW'(xd_q[T2-1].i), sir_pkg::half(k2.ki));
			a2_q[0] <= acc2(k1l_q[T2-T1-1], k2);
			for (int n = 1; n < T3-T2; n++) begin
				a2_q[n] <= a2_q[n-1];
			end
		end
	end

	sir_slope u_k3 (
		.clk(clk), .en(en), .s(y2s_s23), .i(y2i_s23),
		.beta(beta_q), .gam(gam_q), .dt(dt_q), .k(k3)
	);

	// Endpoint state; add 2*k3 to the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			y3s_s34 <= sir_pkg::sat_add(IW'(xd_q[T3-1].s), k3.ks);
			y3i_s34 <= sir_pkg::sat_add(IW'(xd_q[T3-1].i), k3.ki);
			a3_q[0] <= acc2(a2_q[T3-T2-1], k3);
			for (int n = 1; n < T4-T3; n++) begin
				a3_q[n] <= a3_q[n-1];
			end
		end
	end

	sir_slope u_k4 (
		.clk(clk), .en(en), .s(y3s_s34), .i(y3i_s34),
		.beta(beta_q), .gam(gam_q), .dt(dt_q), .k(k4)
	);

	// Finish the weighted sum with k4.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s45.ks <= sir_pkg::sat_add(a3_q[T4-T3-1].ks, k4.ks);
			sum_s45.ki <= sir_pkg::sat_add(a3_q[T4-T3-1].ki, k4.ki);
			sum_s45.kr <= sir_pkg::sat_add(a3_q[T4-T3-1].kr, k4.kr);
		end
	end

	// Divide by six through the reciprocal constant.
	sir_mul u_ds (
		.clk(clk), .en(en), .a(XW'(sum_s45.ks)), .b(XW'(sir_pkg::RECIP_SIX)),
		.sh(sir_pkg::SHW'(sir_pkg::RECIP_FRAC)), .p(scs)
	);
	sir_mul u_di (
		.clk(clk), .en(en), .a(XW'(sum_s45.ki)), .b(XW'(sir_pkg::RECIP_SIX)),
		.sh(sir_pkg::SHW'(sir_pkg::RECIP_FRAC)), .p(sci)
	);
	sir_mul u_dr (
		.clk(clk), .en(en), .a(XW'(sum_s45.kr)), .b(XW'(sir_pkg::RECIP_SIX)),
		.sh(sir_pkg::SHW'(sir_pkg::RECIP_FRAC)), .p(scr)
	);

	// Add the increment to the initial state.
	always_ff @(posedge clk) begin
		if (en) begin
			bs_s49.ks <= sir_pkg::sat_add(IW'(xd_q[XLEN-1].s), scs);
			bs_s49.ki <= sir_pkg::sat_add(IW'(xd_q[XLEN-1].i), sci);
			bs_s49.kr <= sir_pkg::sat_add(IW'(xd_q[XLEN-1].r), scr);
		end
	end

	// Output range clamp.
	always_comb begin
		{fs, es} = emit(bs_s49.ks);
		{fi, ei} = emit(bs_s49.ki);
		{fr, er} = emit(bs_s49.kr);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			so_s50  <= es;
			io_s50  <= ei;
			ro_s50  <= er;
			sat_s50 <= fs | fi | fr;
		end
	end

	assign m_tdata = sir_pkg::OUT_TDW'({ro_s50, io_s50, so_s50});
	assign m_tuser = sat_s50;

	`include "sir_rk4_step_assert.svh"

	// A waiting result blocks new input.
	`SIR_ASSERT_NOW(a_stall_blocks, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	// A stall freezes every valid bit.
	`SIR_ASSERT_NEXT(a_stall_frozen, clk, arst_n, m_tvalid && !m_tready, $stable(vld_q))
	// An accepted item enters the first stage.
	`SIR_ASSERT_NEXT(a_enter, clk, arst_n, s_tvalid && s_tready, vld_q[0])
	// The saturation flag comes with a field at full scale.
	`SIR_ASSERT_NOW(a_sat_max, clk, arst_n, m_tvalid && m_tuser[0], (&so_s50) || (&io_s50) || (&ro_s50))

endmodule

### rtl/sir_mul.sv
// Pipelined signed fixed-point multiply with truncating right shift and saturation.
// Three register stages: partial products, product sum, shift and sign. Uses sir_pkg.
module sir_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [sir_pkg::XW-1:0]   a,
	input  logic signed [sir_pkg::XW-1:0]   b,
	input  logic        [sir_pkg::SHW-1:0]  sh,
	output sir_pkg::ival_t                  p
);

	localparam int HW = sir_pkg::HW;
	localparam int PW = sir_pkg::PW;
	localparam int AW = sir_pkg::AW;
	localparam int IW = sir_pkg::IW;

	logic [AW-1:0]   ma, mb;
	logic [HW-1:0]   al, ah, bl, bh;
	logic [2*HW-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic            neg_s1, neg_s2;
	logic [PW-1:0]   prod_s2;
	logic [PW-1:0]   shifted;
	logic [IW-2:0]   mag;
	sir_pkg::ival_t  p_s3;

	// Magnitudes split into halves.
	always_comb begin
		ma = a[sir_pkg::XW-1] ? AW'(-a) : AW'(a);
		mb = b[sir_pkg::XW-1] ? AW'(-b) : AW'(b);
		al = ma[HW-1:0];
		ah = HW'(ma >> HW);
		bl = mb[HW-1:0];
		bh = HW'(mb >> HW);
	end

	// Stage 1: four partial products and the result sign.
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= (2*HW)'(al) * (2*HW)'(bl);
			lh_s1  <= (2*HW)'(al) * (2*HW)'(bh);
			hl_s1  <= (2*HW)'(ah) * (2*HW)'(bl);
			hh_s1  <= (2*HW)'(ah) * (2*HW)'(bh);
			neg_s1 <= a[sir_pkg::XW-1] ^ b[sir_pkg::XW-1];
		end
	end

	// Stage 2: full product.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(ll_s1) + ((PW'(lh_s1) + PW'(hl_s1)) << HW) + (PW'(hh_s1) << (2*HW));
			neg_s2  <= neg_s1;
		end
	end

	// Shift out the coefficient's fraction bits and clamp the magnitude.
	always_comb begin
		shifted = prod_s2 >> sh;
		if (shifted > PW'(sir_pkg::LIM)) begin
			mag = sir_pkg::LIM[IW-2:0];
		end else begin
			mag = shifted[IW-2:0];
		end
	end

	// Stage 3: apply the sign.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign p = p_s3;

endmodule

### rtl/sir_slope.sv
// One set of SIR slopes times dt: beta*S*I, gamma*I and their dt products.
// Ten register stages built from sir_mul instances. Uses sir_pkg.
module sir_slope (
	input  logic                             clk,
	input  logic                             en,
	input  sir_pkg::ival_t                   s,
	input  sir_pkg::ival_t                   i,
	input  logic [sir_pkg::CFG_WIDTH-1:0]    beta,
	input  logic [sir_pkg::CFG_WIDTH-1:0]    gam,
	input  logic [sir_pkg::CFG_WIDTH-1:0]    dt,
	output sir_pkg::kv_t                     k
);

	localparam int XW  = sir_pkg::XW;
	localparam int SHW = sir_pkg::SHW;

	sir_pkg::ival_t si, inf, rec, ks, ki, kr;
	sir_pkg::ival_t i_s1, i_s2, i_s3;
	sir_pkg::ival_t ninf_s7, dif_s7, rec_s7;

	// S times I.
	sir_mul u_si (
		.clk(clk), .en(en), .a(XW'(s)), .b(XW'(i)),
		.sh(SHW'(sir_pkg::FRAC_BITS)), .p(si)
	);

	// Hold I while S*I is formed.
	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= i;
			i_s2 <= i_s1;
			i_s3 <= i_s2;
		end
	end

	// Infection and recovery terms.
	sir_mul u_inf (
		.clk(clk), .en(en), .a(XW'(beta)), .b(XW'(si)),
		.sh(SHW'(sir_pkg::RATE_FRAC)), .p(inf)
	);
	sir_mul u_rec (
		.clk(clk), .en(en), .a(XW'(gam)), .b(XW'(i_s3)),
		.sh(SHW'(sir_pkg::RATE_FRAC)), .p(rec)
	);

	// Derivatives of S, I and R.
	always_ff @(posedge clk) begin
		if (en) begin
			ninf_s7 <= -inf;
			dif_s7  <= sir_pkg::sat_add(inf, -rec);
			rec_s7  <= rec;
		end
	end

	// Scale each derivative by dt.
	sir_mul u_ks (
		.clk(clk), .en(en), .a(XW'(dt)), .b(XW'(ninf_s7)),
		.sh(SHW'(sir_pkg::STEP_FRAC)), .p(ks)
	);
	sir_mul u_ki (
		.clk(clk), .en(en), .a(XW'(dt)), .b(XW'(dif_s7)),
		.sh(SHW'(sir_pkg::STEP_FRAC)), .p(ki)
	);
	sir_mul u_kr (
		.clk(clk), .en(en), .a(XW'(dt)), .b(XW'(rec_s7)),
		.sh(SHW'(sir_pkg::STEP_FRAC)), .p(kr)
	);

	assign k = '{ks: ks, ki: ki, kr: kr};

endmodule
